@@ design/mfr_pkg.sv @@
// Shared constants for the minmod vertical face reconstruction block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mfr_pkg;

  localparam int DEFAULT_MAX_WIDTH   = 1024;
  localparam int DEFAULT_SAMPLE_BITS = 32;

  localparam int ROW_WIDTH_BITS = 11;
  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;
  localparam int WIDTH_MIN = 3;

endpackage

@@ design/mfr_line_buffer.sv @@
// Dual line buffer: one memory word per column holding {row r-1, row r-2}.
// Registered read with forwarding of a write to the same column. Uses mfr_pkg.
`timescale 1ns / 1ps

module mfr_line_buffer
  import mfr_pkg::*;
#(
  parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int WORD_W = 2 * SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] mem_q;
  logic [WORD_W-1:0] fwd_data;
  logic              fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

@@ design/mfr_limiter.sv @@
// Minmod limited face value with floor halving and saturation.
// Purely combinational; uses mfr_pkg for defaults.
`timescale 1ns / 1ps

module mfr_limiter
  import mfr_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic signed [SAMPLE_BITS-1:0] centre,
  input  logic signed [SAMPLE_BITS-1:0] above,
  input  logic signed [SAMPLE_BITS-1:0] below,
  output logic signed [SAMPLE_BITS-1:0] face
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int FW = SAMPLE_BITS + 2;

  logic signed [DW-1:0] c_ext, a_ext, b_ext;
  logic signed [DW-1:0] da, db, m, half;
  logic signed [FW-1:0] face_wide;
  logic [FW-SAMPLE_BITS:0] top;

  always_comb begin
    c_ext = {centre[SAMPLE_BITS-1], centre};
    a_ext = {above[SAMPLE_BITS-1], above};
    b_ext = {below[SAMPLE_BITS-1], below};
    da    = c_ext - b_ext;
    db    = a_ext - c_ext;
    if (!da[DW-1] && !db[DW-1]) begin
      m = (da <= db) ? da : db;
    end else if ((da[DW-1] || da == '0) && (db[DW-1] || db == '0)) begin
      m = (da >= db) ? da : db;
    end else begin
      m = '0;
    end
    half      = m >>> 1;
    face_wide = {{2{centre[SAMPLE_BITS-1]}}, centre} - {half[DW-1], half};
    top       = face_wide[FW-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      face = face_wide[SAMPLE_BITS-1:0];
    end else if (face_wide[FW-1]) begin
      face = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      face = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

@@ design/minmod_vertical_face_reconstruction.sv @@
// Minmod vertical face reconstruction over a raster stream of height samples.
// Path: an accepted sample is registered into stage s1, and its result is then registered into face_value.
// Throughput: one sample per cycle while sample_stall is low; one line buffer read and one write per sample.
// Reset: synchronous; clears column, row count, pipeline valids, row_width to 1024.
// Line buffer contents are not cleared; output starts only after two full rows.
// Depends on mfr_pkg, mfr_line_buffer and mfr_limiter.
`timescale 1ns / 1ps

module minmod_vertical_face_reconstruction
  import mfr_pkg::*;
#(
  parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] height_sample,
  input  logic                          frame_start,
  output logic                          face_valid,
  input  logic                          face_stall,
  output logic signed [SAMPLE_BITS-1:0] face_value,
  output logic                          row_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ROW_WIDTH_BITS-1:0]     cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int WB     = (CNT_W > ROW_WIDTH_BITS) ? CNT_W : ROW_WIDTH_BITS;
  localparam int WORD_W = 2 * SAMPLE_BITS;

  logic [ROW_WIDTH_BITS-1:0] row_width;
  logic [COL_W-1:0]          column_position, column_position_next;
  logic [1:0]                rows_seen, rows_seen_next;

  logic [WB-1:0]    rw_ext, w_act, w_m1;
  logic [COL_W-1:0] cp_eff, col;
  logic [1:0]       rows_eff;
  logic             last, accept;

  logic                          s1_valid, s1_produce, s1_last;
  logic [COL_W-1:0]              s1_col;
  logic signed [SAMPLE_BITS-1:0] s1_h;
  logic                          s1_move, out_free;

  logic [WORD_W-1:0]             rd_data;
  logic signed [SAMPLE_BITS-1:0] rd_prev, rd_above, face_calc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_width <= cfg_data;
    end
  end

  // active width clamp and column selection
  always_comb begin
    rw_ext = WB'(row_width);
    if (rw_ext < WB'(WIDTH_MIN)) begin
      w_act = WB'(WIDTH_MIN);
    end else if (rw_ext > WB'(MAX_WIDTH)) begin
      w_act = WB'(MAX_WIDTH);
    end else begin
      w_act = rw_ext;
    end
    w_m1     = w_act - WB'(1);
    cp_eff   = frame_start ? '0 : column_position;
    rows_eff = frame_start ? 2'd0 : rows_seen;
    last     = WB'(cp_eff) >= w_m1;
    col      = last ? w_m1[COL_W-1:0] : cp_eff;
    if (last) begin
      column_position_next = '0;
      rows_seen_next       = (rows_eff < 2'd2) ? rows_eff + 2'd1 : rows_eff;
    end else begin
      column_position_next = col + COL_W'(1);
      rows_seen_next       = rows_eff;
    end
  end

  assign out_free     = !face_valid || !face_stall;
  assign s1_move      = s1_valid && (!s1_produce || out_free);
  assign sample_stall = s1_valid && s1_produce && !out_free;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      rows_seen       <= 2'd0;
      s1_valid        <= 1'b0;
    end else begin
      if (accept) begin
        column_position <= column_position_next;
        rows_seen       <= rows_seen_next;
        s1_valid        <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_h       <= height_sample;
      s1_col     <= col;
      s1_last    <= last;
      s1_produce <= rows_eff >= 2'd2;
    end
  end

  mfr_line_buffer #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_buffer (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data ({s1_h, rd_prev}),
    .rd_data (rd_data)
  );

  assign rd_prev  = rd_data[WORD_W-1:SAMPLE_BITS];
  assign rd_above = rd_data[SAMPLE_BITS-1:0];

  mfr_limiter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_limiter (
    .centre (rd_prev),
    .above  (rd_above),
    .below  (s1_h),
    .face   (face_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
    end else if (out_free) begin
      face_valid <= s1_move && s1_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_move && s1_produce) begin
      face_value <= face_calc;
      row_end    <= s1_last;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (face_valid && face_stall && s1_produce))
    else $error("sample stall without a held result");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(face_valid) |-> $past(s1_valid && s1_produce))
    else $error("result without a producing sample in flight");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (WB'(s1_col) < WB'(MAX_WIDTH)))
    else $error("column beyond line buffer depth");

  a_rows_saturate: assert property (@(posedge clk) disable iff (rst)
    (rows_seen == 2'd2 && accept && !frame_start) |=> (rows_seen == 2'd2))
    else $error("row count left saturation without frame start");

endmodule
